[src/cc20_pkg.sv]
package cc20_pkg;

    // state geometry
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned WORDS         = 16;
    localparam int unsigned CTR_W         = 64;
    localparam int unsigned PAIR_W        = 64;
    localparam int unsigned DOUBLE_ROUNDS = 10;

    // quarter-round rotation amounts
    localparam int unsigned ROT_A = 16;
    localparam int unsigned ROT_B = 12;
    localparam int unsigned ROT_C = 8;
    localparam int unsigned ROT_D = 7;

    // fixed constant words 0..3
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_A      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_B      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_C      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_D      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LOW_PAIR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HIGH_PAIR = 3'd5;

    // stream widths
    localparam int unsigned S_TDATA_W = 8;

    typedef logic [WORDS-1:0][WORD_W-1:0] word_arr_t;

    // one block in flight: word 0 in the lowest bits, counter on top
    typedef struct packed {
        logic [CTR_W-1:0] ctr;
        word_arr_t        words;
    } beat_t;

    localparam int unsigned M_TDATA_W = $bits(beat_t);

    function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int unsigned n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} << n;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    // half of a column or diagonal round: all four quarter-rounds, first or second half
    function automatic word_arr_t half_round(word_arr_t s, logic diag, logic second);
        word_arr_t     t;
        logic [1:0]    q2;
        logic [3:0]    ia;
        logic [3:0]    ib;
        logic [3:0]    ic;
        logic [3:0]    id;
        logic [WORD_W-1:0] va;
        logic [WORD_W-1:0] vb;
        logic [WORD_W-1:0] vc;
        logic [WORD_W-1:0] vd;
        t = s;
        for (int unsigned q = 0; q < 4; q++) begin
            q2 = 2'(q);
            ia = {2'd0, q2};
            ib = {2'd1, q2 + {1'b0, diag}};
            ic = {2'd2, q2 + {diag, 1'b0}};
            id = {2'd3, q2 + {diag, diag}};
            va = t[ia] + t[ib];
            vd = rotl(t[id] ^ va, second ? ROT_C : ROT_A);
            vc = t[ic] + vd;
            vb = rotl(t[ib] ^ vc, second ? ROT_D : ROT_B);
            t[ia] = va;
            t[ib] = vb;
            t[ic] = vc;
            t[id] = vd;
        end
        return t;
    endfunction

endpackage

[src/cc20_round_pipe.sv]
module cc20_round_pipe #(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cc20_pkg::beat_t in_beat,
    output logic            out_valid,
    output cc20_pkg::beat_t out_beat
);

    // one stage per half round, four per double round
    localparam int unsigned NSTAGE = 4 * DOUBLE_ROUNDS;

    logic            valid_reg [NSTAGE];
    cc20_pkg::beat_t beat_reg  [NSTAGE];

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        localparam logic DIAG   = 1'((k / 2) % 2);
        localparam logic SECOND = 1'(k % 2);

        logic            v_in;
        cc20_pkg::beat_t b_in;

        // stage input from the block input or the previous stage
        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign b_in = in_beat;
        end
        else begin : g_chain
            assign v_in = valid_reg[k-1];
            assign b_in = beat_reg[k-1];
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        // state words and counter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                beat_reg[k].ctr   <= b_in.ctr;
                beat_reg[k].words <= cc20_pkg::half_round(b_in.words, DIAG, SECOND);
            end
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign out_beat  = beat_reg[NSTAGE-1];

endmodule

[src/cc20_out_buf.sv]
module cc20_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cc20_pkg::beat_t push_beat,
    input  logic            m_tready,
    output logic            m_tvalid,
    output cc20_pkg::beat_t out_beat,
    output logic            full
);

    logic            out_valid_reg;
    logic            out_valid_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    cc20_pkg::beat_t out_beat_reg;
    cc20_pkg::beat_t skid_beat_reg;
    logic            pop;
    logic            load_out_skid;
    logic            load_out_push;
    logic            load_skid;

    assign pop = out_valid_reg & m_tready;

    // output register plus one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_skid   = 1'b0;
        load_out_push   = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                load_out_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                load_out_push  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            out_beat_reg <= skid_beat_reg;
        end
        else if (load_out_push)
        begin
            out_beat_reg <= push_beat;
        end
        if (load_skid)
        begin
            skid_beat_reg <= push_beat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_beat = out_beat_reg;
    assign full     = skid_valid_reg;

endmodule

[src/chacha20_keystream_block.sv]
// ChaCha keystream block generator, one 64-byte block per request beat.
// Configuration: write cfg_data to register cfg_index when cfg_valid and cfg_ready
// are high (cfg_ready is always high). Indexes 0..3 load key word pairs 4/5 .. 10/11,
// 4 the nonce pair for words 12/13, 5 the nonce pair for words 14/15; other
// indexes are dropped. Write only while no block is in flight.
// Request: an s_tdata beat; bit 0 set restarts the block counter at 1 first.
// Result: one m_tdata beat with output words 0..15 (word 0 in the lowest bits)
// and the 64-bit counter mixed into that block in the top bits.
// Path from request beat to m_tvalid: input register, one stage per half round,
// and the output register that also does the final add of the base words.
// Throughput: one block per cycle while the skid entry is empty; each pipeline
// stage holds a separate block.
// Reset: all key and nonce registers read zero and the counter is 1.
// Receiver stall: a skid entry behind the output register takes one more block,
// then the whole pipeline holds and s_tready drops until the skid entry drains.
module chacha20_keystream_block #(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cc20_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cc20_pkg::PAIR_W-1:0]         cfg_data,
    // request: [0] reseed, [7:1] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cc20_pkg::S_TDATA_W-1:0]      s_tdata,
    // result: [63:0] block_word_0_1, [127:64] block_word_2_3, ...,
    // [511:448] block_word_14_15, [575:512] counter_used
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cc20_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic [cc20_pkg::PAIR_W-1:0] key_a_reg;
    logic [cc20_pkg::PAIR_W-1:0] key_b_reg;
    logic [cc20_pkg::PAIR_W-1:0] key_c_reg;
    logic [cc20_pkg::PAIR_W-1:0] key_d_reg;
    logic [cc20_pkg::PAIR_W-1:0] nonce_lo_reg;
    logic [cc20_pkg::PAIR_W-1:0] nonce_hi_reg;
    logic [cc20_pkg::CTR_W-1:0]  ctr_reg;
    logic [cc20_pkg::CTR_W-1:0]  ctr_use;
    logic [cc20_pkg::CTR_W-1:0]  ctr_next;
    logic                        in_valid_reg;
    cc20_pkg::beat_t             in_beat_reg;
    cc20_pkg::beat_t             in_beat_next;
    cc20_pkg::word_arr_t         base;
    logic                        en;
    logic                        accept;
    logic                        skid_full;
    logic                        pipe_valid;
    cc20_pkg::beat_t             pipe_beat;
    cc20_pkg::beat_t             fin_beat;
    cc20_pkg::beat_t             out_beat;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg    <= '0;
            key_b_reg    <= '0;
            key_c_reg    <= '0;
            key_d_reg    <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cc20_pkg::CFG_KEY_PAIR_A:      key_a_reg    <= cfg_data;
                cc20_pkg::CFG_KEY_PAIR_B:      key_b_reg    <= cfg_data;
                cc20_pkg::CFG_KEY_PAIR_C:      key_c_reg    <= cfg_data;
                cc20_pkg::CFG_KEY_PAIR_D:      key_d_reg    <= cfg_data;
                cc20_pkg::CFG_NONCE_LOW_PAIR:  nonce_lo_reg <= cfg_data;
                cc20_pkg::CFG_NONCE_HIGH_PAIR: nonce_hi_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // base state without the counter
    always_comb
    begin
        base[0]  = cc20_pkg::SIGMA_0;
        base[1]  = cc20_pkg::SIGMA_1;
        base[2]  = cc20_pkg::SIGMA_2;
        base[3]  = cc20_pkg::SIGMA_3;
        base[4]  = key_a_reg[31:0];
        base[5]  = key_a_reg[63:32];
        base[6]  = key_b_reg[31:0];
        base[7]  = key_b_reg[63:32];
        base[8]  = key_c_reg[31:0];
        base[9]  = key_c_reg[63:32];
        base[10] = key_d_reg[31:0];
        base[11] = key_d_reg[63:32];
        base[12] = nonce_lo_reg[31:0];
        base[13] = nonce_lo_reg[63:32];
        base[14] = nonce_hi_reg[31:0];
        base[15] = nonce_hi_reg[63:32];
    end

    // pipeline advances unless the skid entry is occupied
    assign en       = !skid_full;
    assign s_tready = en;
    assign accept   = s_tvalid & en;

    // block counter, restarted on reseed or wrap to zero
    always_comb
    begin
        ctr_use  = (s_tdata[0] || ctr_reg == '0) ? cc20_pkg::CTR_W'(1) : ctr_reg;
        ctr_next = ctr_use + cc20_pkg::CTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= cc20_pkg::CTR_W'(1);
        end
        else if (accept)
        begin
            ctr_reg <= ctr_next;
        end
    end

    // initial state with the counter folded into words 12 and 13
    always_comb
    begin
        in_beat_next           = '{ctr: ctr_use, words: base};
        in_beat_next.words[12] = base[12] ^ ctr_use[31:0];
        in_beat_next.words[13] = base[13] ^ ctr_use[63:32];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg <= in_beat_next;
        end
    end

    cc20_round_pipe #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_rounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_beat   (in_beat_reg),
        .out_valid (pipe_valid),
        .out_beat  (pipe_beat)
    );

    // feed-forward add of the base words
    always_comb
    begin
        fin_beat.ctr = pipe_beat.ctr;
        for (int unsigned i = 0; i < cc20_pkg::WORDS; i++)
        begin
            fin_beat.words[i] = pipe_beat.words[i] + base[i];
        end
    end

    cc20_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pipe_valid & en),
        .push_beat (fin_beat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_beat  (out_beat),
        .full      (skid_full)
    );

    assign m_tdata = out_beat;

endmodule

[tb/sv/chacha20_keystream_block_checker.sv]
`timescale 1ns / 100ps

module chacha20_keystream_block_checker
    import cc20_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int unsigned            mismatch_count,
    output int unsigned            blocks_pending
);

    localparam int unsigned KN_REGS    = CFG_NONCE_HIGH_PAIR + 1;
    localparam int unsigned PAIRS      = WORDS / 2;
    localparam int unsigned REPORT_MAX = 40;

    typedef logic [WORDS-1:0][WORD_W-1:0] state_t;

    // same layout as a result beat: pair 0 in the lowest bits, counter on top
    typedef struct packed {
        logic [CTR_W-1:0]             counter;
        logic [PAIRS-1:0][PAIR_W-1:0] pairs;
    } keystream_t;

    logic [KN_REGS-1:0][PAIR_W-1:0] key_nonce;
    logic [CTR_W-1:0]               block_ctr;
    keystream_t                     expected_blocks[$];

    function automatic logic [WORD_W-1:0] rol32(logic [WORD_W-1:0] v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic state_t quarter(state_t s, int unsigned a, int unsigned b,
                                       int unsigned c, int unsigned d);
        s[a] = s[a] + s[b];
        s[d] = rol32(s[d] ^ s[a], ROT_A);
        s[c] = s[c] + s[d];
        s[b] = rol32(s[b] ^ s[c], ROT_B);
        s[a] = s[a] + s[b];
        s[d] = rol32(s[d] ^ s[a], ROT_C);
        s[c] = s[c] + s[d];
        s[b] = rol32(s[b] ^ s[c], ROT_D);
        return s;
    endfunction

    // one keystream block from key/nonce pairs and the counter to mix in
    function automatic keystream_t chacha_block(logic [KN_REGS-1:0][PAIR_W-1:0] kn,
                                                logic [CTR_W-1:0] ctr);
        state_t     base;
        state_t     x;
        keystream_t blk;
        base[0] = SIGMA_0;
        base[1] = SIGMA_1;
        base[2] = SIGMA_2;
        base[3] = SIGMA_3;
        for (int i = 0; i < KN_REGS; i++)
        begin
            base[4 + 2*i] = kn[i][WORD_W-1:0];
            base[5 + 2*i] = kn[i][PAIR_W-1:WORD_W];
        end
        // counter is xored into words 12 and 13, not written over them
        x = base;
        x[12] = x[12] ^ ctr[WORD_W-1:0];
        x[13] = x[13] ^ ctr[CTR_W-1:WORD_W];
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            x = quarter(x, 0, 4, 8, 12);
            x = quarter(x, 1, 5, 9, 13);
            x = quarter(x, 2, 6, 10, 14);
            x = quarter(x, 3, 7, 11, 15);
            x = quarter(x, 0, 5, 10, 15);
            x = quarter(x, 1, 6, 11, 12);
            x = quarter(x, 2, 7, 8, 13);
            x = quarter(x, 3, 4, 9, 14);
        end
        // feed-forward uses the base words without the counter
        for (int i = 0; i < WORDS; i++)
        begin
            x[i] = x[i] + base[i];
        end
        for (int i = 0; i < PAIRS; i++)
        begin
            blk.pairs[i] = {x[2*i + 1], x[2*i]};
        end
        blk.counter = ctr;
        return blk;
    endfunction

    // watch config, request and result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        keystream_t       want;
        keystream_t       got;
        logic [CTR_W-1:0] ctr;
        int unsigned      bad;
        if (!rst_n)
        begin
            key_nonce = '0;
            block_ctr = CTR_W'(1);
            expected_blocks.delete();
            mismatch_count <= 0;
            blocks_pending <= 0;
        end
        else
        begin
            bad = 0;
            // register writes; spare indexes are dropped
            if (cfg_valid && cfg_ready && cfg_index <= CFG_NONCE_HIGH_PAIR)
                key_nonce[cfg_index] = cfg_data;

            // compare a result beat against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_blocks.size() == 0)
                begin
                    bad++;
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: unexpected block, expected none got counter %h",
                                 $time, got.counter);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    for (int i = 0; i < PAIRS; i++)
                    begin
                        if (got.pairs[i] !== want.pairs[i])
                        begin
                            bad++;
                            if (mismatch_count + bad <= REPORT_MAX)
                                $display("%0t: block_word_%0d_%0d expected %h got %h",
                                         $time, 2*i, 2*i + 1, want.pairs[i], got.pairs[i]);
                        end
                    end
                    if (got.counter !== want.counter)
                    begin
                        bad++;
                        if (mismatch_count + bad <= REPORT_MAX)
                            $display("%0t: counter_used expected %h got %h",
                                     $time, want.counter, got.counter);
                    end
                end
            end

            // request beat: pick the counter, advance, predict
            if (s_tvalid && s_tready)
            begin
                if (s_tdata[0] || block_ctr == '0)
                    ctr = CTR_W'(1);
                else
                    ctr = block_ctr;
                block_ctr = ctr + CTR_W'(1);
                expected_blocks.push_back(chacha_block(key_nonce, ctr));
            end

            mismatch_count <= mismatch_count + bad;
            blocks_pending <= expected_blocks.size();
        end
    end

endmodule

[tb/sv/chacha20_keystream_block_tb.sv]
`timescale 1ns / 100ps

module chacha20_keystream_block_tb;

    import cc20_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned PHASE_ITEMS    = 420;
    localparam int unsigned PRESSURE_ITEMS = 120;
    localparam int unsigned RESEED_PCT     = 12;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_MIXED} fill_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PAIR_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int unsigned mismatch_count;
    int unsigned blocks_pending;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    chacha20_keystream_block dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    chacha20_keystream_block_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .blocks_pending (blocks_pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [PAIR_W-1:0] pick_value(fill_t fill);
        fill_t kind;
        kind = fill;
        if (kind == FILL_MIXED)
        begin
            case ($urandom_range(7))
                0:       kind = FILL_ZERO;
                1:       kind = FILL_ONES;
                default: kind = FILL_RANDOM;
            endcase
        end
        case (kind)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            default:   return {$urandom, $urandom};
        endcase
    endfunction

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] index, input logic [PAIR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // write all six key/nonce registers, then both spare indexes
    task automatic load_config(input fill_t fill, input fill_t spare_fill);
        for (int r = CFG_KEY_PAIR_A; r <= CFG_NONCE_HIGH_PAIR; r++)
        begin
            put_reg(CFG_INDEX_W'(r), pick_value(fill));
        end
        put_reg(CFG_SPARE_LO, pick_value(spare_fill));
        put_reg(CFG_SPARE_HI, pick_value(spare_fill));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(input logic reseed);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, reseed};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic run_burst(input int unsigned count);
        for (int i = 0; i < count; i++)
        begin
            send_request($urandom_range(99) < RESEED_PCT);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (blocks_pending != 0)
            @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        int unsigned tx_mode[4];
        int unsigned rx_mode[4];
        tx_mode = '{0, 64, 0, 28};
        rx_mode = '{0, 0, 64, 28};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: counter from 1, advancing, reseed restarts it
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        s_tvalid <= 1'b0;
        drain();

        // all-ones key and nonce
        load_config(FILL_ONES, FILL_ONES);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        s_tvalid <= 1'b0;
        drain();

        // zero registers, spare indexes written with ones must not leak in
        load_config(FILL_ZERO, FILL_ONES);
        send_request(1'b0);
        send_request(1'b1);
        s_tvalid <= 1'b0;
        drain();

        load_config(FILL_RANDOM, FILL_RANDOM);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        s_tvalid <= 1'b0;
        drain();

        // random phases under different idle patterns
        for (int p = 0; p < 4; p++)
        begin
            load_config(FILL_MIXED, FILL_RANDOM);
            tx_idle_pct  = tx_mode[p];
            rx_stall_pct <= rx_mode[p];
            run_burst(PHASE_ITEMS);
            drain();

            // receiver holds off while the sender keeps pushing
            if (p == 0)
            begin
                hold_requests <= hold_requests + 1;
                run_burst(PRESSURE_ITEMS);
                drain();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && blocks_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
